// File: hw/rtl/sfae_pkg.sv
// Shared types and constants for the sprite frame animation engine.
// Used by every module of the block; depends on nothing.
package sfae_pkg;

  // Input item modes
  localparam logic [2:0] MODE_TICK  = 3'd0;
  localparam logic [2:0] MODE_WRITE = 3'd1;
  localparam logic [2:0] MODE_SEQ   = 3'd2;
  localparam logic [2:0] MODE_RANGE = 3'd3;
  localparam logic [2:0] MODE_QUERY = 3'd4;

  // LCG for random frame durations
  localparam logic [31:0] LCG_SEED_INIT = 32'h1234_5678;
  localparam logic [31:0] LCG_MUL       = 32'd1664525;
  localparam logic [31:0] LCG_INC       = 32'd1013904223;

  localparam int DIV_NUM_W   = 32;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_RANGE = 2'd1,
    KIND_SEQ   = 2'd2
  } kind_t;

  // Operation as classified by the front end
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_WRITE = 3'd1,
    OP_SEQ   = 3'd2,
    OP_RANGE = 3'd3,
    OP_QUERY = 3'd4,
    OP_QNONE = 3'd5
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [4:0]  channel;
    logic [3:0]  frame_slot;
    logic [15:0] picture;
    logic [15:0] range_last;
    logic [15:0] tics_low;
    logic [15:0] tics_high;
    logic        random_tics;
    logic [4:0]  frame_count;
    logic        animate;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE  = 4'd0,
    BK_WALK  = 4'd1,
    BK_FRD   = 4'd2,
    BK_MOD   = 4'd3,
    BK_LOAD  = 4'd4,
    BK_QDIV1 = 4'd5,
    BK_QDIV2 = 4'd6,
    BK_QFRD  = 4'd7
  } bk_state_t;

endpackage

// File: hw/rtl/sfae_if.sv
// Channel interfaces of the animation engine: input items and query results.
// Depends on nothing.
interface sfae_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [4:0]  channel;
  logic [3:0]  frame_slot;
  logic [15:0] picture;
  logic [15:0] range_last;
  logic [15:0] tics_low;
  logic [15:0] tics_high;
  logic        random_tics;
  logic [4:0]  frame_count;
  logic        animate;

  modport source (output valid, mode, channel, frame_slot, picture, range_last,
                  tics_low, tics_high, random_tics, frame_count, animate,
                  input ready);
  modport sink (input valid, mode, channel, frame_slot, picture, range_last,
                tics_low, tics_high, random_tics, frame_count, animate,
                output ready);
endinterface

interface sfae_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] picture_out;
  logic        valid_res;

  modport source (output valid, picture_out, valid_res, input ready);
  modport sink (input valid, picture_out, valid_res, output ready);
endinterface

// File: hw/rtl/sprite_frame_animation_engine.sv
// Top level of the sprite frame animation engine: front end, command queue
// and back end. Depends on sfae_pkg, sfae_if and the sfae_* modules.
//
//   port     | direction | carries
//   ---------+-----------+-----------------------------------------------
//   in_ch    | sink      | tick, write frame, set sequence/range, query
//   out_ch   | source    | picture_out and valid_res for each query
//
// Writes and set commands finish in idle. A tick walks every channel one a
// cycle; a channel due for a reload adds BK_FRD and BK_LOAD, and a random
// duration also BK_MOD (one quotient bit a cycle in the shared divider). An
// animated range query divides twice in the same divider. Reset is synchronous;
// the channel table clears at once, range records apart. The front end keeps
// taking items into a 4-entry queue while the back end works or out_ch stalls.
module sprite_frame_animation_engine
  import sfae_pkg::*;
#(
  parameter int CHANNELS           = 32,
  parameter int FRAMES_PER_CHANNEL = 16,
  parameter int PICTURE_BITS       = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  sfae_in_if.sink    in_ch,
  sfae_out_if.source out_ch
);

  logic q_full, q_push, q_pop, q_empty;
  cmd_t q_in, q_head;

  sfae_front #(
    .CHANNELS           (CHANNELS),
    .FRAMES_PER_CHANNEL (FRAMES_PER_CHANNEL)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  sfae_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  sfae_back #(
    .CHANNELS           (CHANNELS),
    .FRAMES_PER_CHANNEL (FRAMES_PER_CHANNEL),
    .PICTURE_BITS       (PICTURE_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: hw/rtl/sfae_front.sv
// Front end: accepts input items, drops the meaningless ones and classifies
// the rest into commands for the queue. Depends on sfae_pkg and sfae_if.
module sfae_front
  import sfae_pkg::*;
#(
  parameter int CHANNELS           = 32,
  parameter int FRAMES_PER_CHANNEL = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  sfae_in_if.sink  in_ch,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_data
);

  logic ch_ok;
  logic slot_ok;
  logic keep;
  logic [4:0] count_sat;

  assign ch_ok   = 32'(in_ch.channel) < 32'(CHANNELS);
  assign slot_ok = 32'(in_ch.frame_slot) < 32'(FRAMES_PER_CHANNEL);
  assign count_sat = (32'(in_ch.frame_count) > 32'(FRAMES_PER_CHANNEL)) ?
                     5'(FRAMES_PER_CHANNEL) : in_ch.frame_count;

  // Classify the item
  always_comb begin
    keep = 1'b0;
    q_data.op = OP_TICK;
    case (in_ch.mode)
      MODE_TICK: begin
        keep = 1'b1;
      end
      MODE_WRITE: begin
        keep = ch_ok && slot_ok;
        q_data.op = OP_WRITE;
      end
      MODE_SEQ: begin
        keep = ch_ok;
        q_data.op = OP_SEQ;
      end
      MODE_RANGE: begin
        keep = ch_ok;
        q_data.op = OP_RANGE;
      end
      MODE_QUERY: begin
        keep = 1'b1;
        q_data.op = ch_ok ? OP_QUERY : OP_QNONE;
      end
      default: keep = 1'b0;
    endcase
    q_data.channel     = in_ch.channel;
    q_data.frame_slot  = in_ch.frame_slot;
    q_data.picture     = in_ch.picture;
    q_data.range_last  = in_ch.range_last;
    q_data.tics_low    = in_ch.tics_low;
    q_data.tics_high   = in_ch.tics_high;
    q_data.random_tics = in_ch.random_tics;
    q_data.frame_count = count_sat;
    q_data.animate     = in_ch.animate;
  end

  // Transfer whenever the queue has room once out of reset; dropped items are taken too
  logic busy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= 1'b1;
    end
  end

  assign in_ch.ready = busy_r && !q_full;
  assign q_push      = in_ch.valid && in_ch.ready && keep;

endmodule

// File: hw/rtl/sfae_queue.sv
// Short command queue between front end and back end.
// Depends on sfae_pkg.
module sfae_queue
  import sfae_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_r;
  logic [PW-1:0] rd_r;
  logic [PW:0]   cnt_r;

  assign full  = cnt_r == (PW+1)'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_r];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/sfae_div.sv
// Restoring divider, one quotient bit a cycle; gives quotient and remainder.
// Depends on sfae_pkg.
module sfae_div
  import sfae_pkg::*;
#(
  parameter int DEN_W = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DEN_W-1:0]     den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quot,
  output logic [DEN_W-1:0]     rem
);

  localparam int CW = $clog2(DIV_NUM_W + 1);

  logic [DIV_NUM_W-1:0] quo_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     den_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DEN_W:0]       trial;
  logic                 fits;

  assign trial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  // Load on start, then shift one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NUM_W-2:0], fits};
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

// File: hw/rtl/sfae_back.sv
// Back end: carries out queued commands over the channel table and frame
// memory, walks all channels on a tick. Depends on sfae_pkg, sfae_div, sfae_if.
module sfae_back
  import sfae_pkg::*;
#(
  parameter int CHANNELS           = 32,
  parameter int FRAMES_PER_CHANNEL = 16,
  parameter int PICTURE_BITS       = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  logic      q_empty,
  output logic      q_pop,
  sfae_out_if.source out_ch
);

  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W    = (FRAMES_PER_CHANNEL > 1) ? $clog2(FRAMES_PER_CHANNEL) : 1;
  localparam int LEN_W    = $clog2(FRAMES_PER_CHANNEL + 1);
  localparam int FR_DEPTH = CHANNELS * FRAMES_PER_CHANNEL;
  localparam int FR_AW    = (FR_DEPTH > 1) ? $clog2(FR_DEPTH) : 1;
  localparam int DEN_W    = ((PICTURE_BITS > 16) ? PICTURE_BITS : 16) + 1;

  typedef struct packed {
    logic                    rnd;
    logic [15:0]             tmax;
    logic [15:0]             tmin;
    logic [PICTURE_BITS-1:0] pic;
  } frame_t;

  // Channel table
  kind_t                   kind_r  [CHANNELS];
  logic [LEN_W-1:0]        len_r   [CHANNELS];
  logic [POS_W-1:0]        pos_r   [CHANNELS];
  logic [15:0]             rem_r   [CHANNELS];
  logic [PICTURE_BITS-1:0] first_r [CHANNELS];
  logic [PICTURE_BITS-1:0] last_r  [CHANNELS];
  logic [15:0]             tics_r  [CHANNELS];
  logic                    rok_r   [CHANNELS];

  // Frame memory
  frame_t frame_mem [FR_DEPTH];
  frame_t fr_rd_r;

  bk_state_t state_r, state_nxt;
  logic [CH_W-1:0] walk_r;
  logic [31:0]     tick_r;
  logic [31:0]     seed_r;
  logic [15:0]     t_r;
  logic            out_full_r;
  logic [15:0]     out_pic_r;
  logic            out_ok_r;

  // Decoded view of the addressed channel
  logic [CH_W-1:0]  cmd_ch, cur_ch;
  kind_t            cur_kind;
  logic [LEN_W-1:0] cur_len;
  logic [POS_W-1:0] cur_pos, pos_eff, pos_adv, qpos;
  logic [15:0]      cur_rem;
  logic             seq_act, walk_last, in_walk;
  logic [LEN_W:0]   pos_inc;

  assign cmd_ch  = CH_W'(cmd.channel);
  assign in_walk = (state_r == BK_WALK) || (state_r == BK_FRD) ||
                   (state_r == BK_MOD) || (state_r == BK_LOAD);
  assign cur_ch  = in_walk ? walk_r : cmd_ch;
  assign cur_kind = kind_r[cur_ch];
  assign cur_len  = len_r[cur_ch];
  assign cur_pos  = pos_r[cur_ch];
  assign cur_rem  = rem_r[cur_ch];
  assign seq_act  = (cur_kind == KIND_SEQ) && (cur_len != '0);
  assign walk_last = walk_r == CH_W'(CHANNELS - 1);
  assign pos_eff  = (LEN_W'(cur_pos) >= cur_len) ? '0 : cur_pos;
  assign pos_inc  = (LEN_W+1)'(pos_eff) + 1'b1;
  assign pos_adv  = (pos_inc >= (LEN_W+1)'(cur_len)) ? '0 : POS_W'(pos_inc);
  assign qpos     = (cmd.animate && (LEN_W'(cur_pos) < cur_len)) ? cur_pos : '0;

  // Frame duration draw
  logic [15:0] lo, hi;
  logic        rnd_div;
  logic [31:0] seed_nxt;
  logic [16:0] span_rnd;

  assign lo       = fr_rd_r.tmin;
  assign hi       = (fr_rd_r.tmax < fr_rd_r.tmin) ? fr_rd_r.tmin : fr_rd_r.tmax;
  assign rnd_div  = fr_rd_r.rnd && (hi > lo);
  assign seed_nxt = seed_r * LCG_MUL + LCG_INC;
  assign span_rnd = {1'b0, hi} - {1'b0, lo} + 17'd1;

  // Countdown step shared by walk and reload
  logic [15:0] t_eff, dec_src, dec;
  assign t_eff   = (t_r == '0) ? 16'd1 : t_r;
  assign dec_src = (state_r == BK_LOAD) ? t_eff : cur_rem;
  assign dec     = dec_src - 16'd1;

  // Range query
  logic [DEN_W-1:0] span_rng;
  logic             range_anim;
  assign span_rng   = DEN_W'(last_r[cmd_ch]) - DEN_W'(first_r[cmd_ch]) + 1'b1;
  assign range_anim = (cur_kind == KIND_RANGE) && rok_r[cmd_ch] && cmd.animate;

  // Divider
  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0]     div_den, div_rem;

  sfae_div #(.DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          if (cmd.op == OP_TICK) begin
            state_nxt = BK_WALK;
          end else if ((cmd.op == OP_QUERY) && !out_full_r) begin
            if (range_anim) begin
              state_nxt = BK_QDIV1;
            end else if ((cur_kind == KIND_SEQ) && (cur_len != '0)) begin
              state_nxt = BK_QFRD;
            end
          end
        end
      end
      BK_WALK: begin
        if (seq_act && (cur_rem == '0)) begin
          state_nxt = BK_FRD;
        end else if (walk_last) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_FRD:   state_nxt = rnd_div ? BK_MOD : BK_LOAD;
      BK_MOD:   if (div_done) state_nxt = BK_LOAD;
      BK_LOAD:  state_nxt = walk_last ? BK_IDLE : BK_WALK;
      BK_QDIV1: if (div_done) state_nxt = BK_QDIV2;
      BK_QDIV2: if (div_done) state_nxt = BK_IDLE;
      BK_QFRD:  state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer
  logic             mem_we, out_load, out_ok_nxt, walk_step;
  logic [15:0]      out_pic_nxt;
  logic [FR_AW-1:0] wr_addr, rd_addr;
  logic [POS_W-1:0] rd_slot;

  assign wr_addr = FR_AW'(cmd_ch) * FR_AW'(FRAMES_PER_CHANNEL) + FR_AW'(cmd.frame_slot);
  assign rd_slot = in_walk ? pos_eff : qpos;
  assign rd_addr = FR_AW'(cur_ch) * FR_AW'(FRAMES_PER_CHANNEL) + FR_AW'(rd_slot);

  always_comb begin
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    out_load    = 1'b0;
    out_pic_nxt = '0;
    out_ok_nxt  = 1'b0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    walk_step   = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          case (cmd.op)
            OP_WRITE: begin
              mem_we = 1'b1;
              q_pop  = 1'b1;
            end
            OP_SEQ, OP_RANGE: q_pop = 1'b1;
            OP_QNONE: begin
              if (!out_full_r) begin
                out_load = 1'b1;
                q_pop    = 1'b1;
              end
            end
            OP_QUERY: begin
              if (!out_full_r) begin
                if (range_anim) begin
                  div_start = 1'b1;
                  div_num   = tick_r;
                  div_den   = DEN_W'(tics_r[cmd_ch]);
                end else if (cur_kind == KIND_RANGE) begin
                  out_load    = 1'b1;
                  out_pic_nxt = 16'(first_r[cmd_ch]);
                  out_ok_nxt  = rok_r[cmd_ch];
                  q_pop       = 1'b1;
                end else if (!((cur_kind == KIND_SEQ) && (cur_len != '0))) begin
                  out_load = 1'b1;
                  q_pop    = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      BK_WALK: begin
        if (!(seq_act && (cur_rem == '0))) begin
          walk_step = 1'b1;
          q_pop     = walk_last;
        end
      end
      BK_FRD: begin
        if (rnd_div) begin
          div_start = 1'b1;
          div_num   = seed_nxt;
          div_den   = DEN_W'(span_rnd);
        end
      end
      BK_LOAD: begin
        walk_step = 1'b1;
        q_pop     = walk_last;
      end
      BK_QDIV1: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = div_quot;
          div_den   = span_rng;
        end
      end
      BK_QDIV2: begin
        if (div_done) begin
          out_load    = 1'b1;
          out_pic_nxt = 16'(first_r[cmd_ch] + PICTURE_BITS'(div_rem));
          out_ok_nxt  = 1'b1;
          q_pop       = 1'b1;
        end
      end
      BK_QFRD: begin
        out_load    = 1'b1;
        out_pic_nxt = 16'(fr_rd_r.pic);
        out_ok_nxt  = 1'b1;
        q_pop       = 1'b1;
      end
      default: ;
    endcase
  end

  // Frame memory: write from the queue, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[wr_addr] <= '{rnd: cmd.random_tics, tmax: cmd.tics_high,
                              tmin: cmd.tics_low,
                              pic: PICTURE_BITS'(cmd.picture)};
    end
    fr_rd_r <= frame_mem[rd_addr];
  end

  // Range records, undefined until written
  always_ff @(posedge clk) begin
    if ((state_r == BK_IDLE) && !q_empty && (cmd.op == OP_RANGE)) begin
      first_r[cmd_ch] <= PICTURE_BITS'(cmd.picture);
      last_r[cmd_ch]  <= PICTURE_BITS'(cmd.range_last);
      tics_r[cmd_ch]  <= cmd.tics_low;
      rok_r[cmd_ch]   <= (PICTURE_BITS'(cmd.picture) < PICTURE_BITS'(cmd.range_last)) &&
                         (cmd.tics_low != '0);
    end
  end

  // Channel table, time counter, seed and sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      walk_r  <= '0;
      tick_r  <= '0;
      seed_r  <= LCG_SEED_INIT;
      for (int c = 0; c < CHANNELS; c++) begin
        kind_r[c] <= KIND_NONE;
        len_r[c]  <= '0;
        pos_r[c]  <= '0;
        rem_r[c]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // apply the tick and set commands
      if ((state_r == BK_IDLE) && !q_empty) begin
        case (cmd.op)
          OP_TICK: begin
            tick_r <= tick_r + 32'd1;
            walk_r <= '0;
          end
          OP_SEQ, OP_RANGE: begin
            kind_r[cmd_ch] <= (cmd.op == OP_SEQ) ? KIND_SEQ : KIND_RANGE;
            len_r[cmd_ch]  <= (cmd.op == OP_SEQ) ? LEN_W'(cmd.frame_count) : '0;
            pos_r[cmd_ch]  <= '0;
            rem_r[cmd_ch]  <= '0;
          end
          default: ;
        endcase
      end
      // count down, reload and advance the walked channel
      if ((state_r == BK_WALK) && seq_act) begin
        if (cur_rem == '0) begin
          pos_r[cur_ch] <= pos_eff;
        end else begin
          rem_r[cur_ch] <= dec;
          pos_r[cur_ch] <= (dec == '0) ? pos_adv : pos_eff;
        end
      end
      if (state_r == BK_LOAD) begin
        rem_r[cur_ch] <= dec;
        pos_r[cur_ch] <= (dec == '0) ? pos_adv : pos_eff;
      end
      if (state_r == BK_FRD) begin
        t_r <= lo;
        if (fr_rd_r.rnd) begin
          seed_r <= seed_nxt;
        end
      end
      if ((state_r == BK_MOD) && div_done) begin
        t_r <= t_r + 16'(div_rem);
      end
      if (walk_step && !walk_last) begin
        walk_r <= walk_r + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_full_r <= 1'b0;
    end else if (out_load) begin
      out_full_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pic_r <= out_pic_nxt;
      out_ok_r  <= out_ok_nxt;
    end
  end

  assign out_ch.valid       = out_full_r;
  assign out_ch.picture_out = out_pic_r;
  assign out_ch.valid_res   = out_ok_r;

endmodule
